// ----- rtl/multiplexed_seven_segment_driver_defines.svh -----
// assertion macros for the seven-segment driver
// used by modules that check their own control logic; needs clk and arst_n in scope
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_DEFINES_SVH

// condition implies a consequence in the same cycle
`define MSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies a consequence in the next cycle
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant that holds in every cycle
`define MSD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ----- rtl/msd_pkg.sv -----
// shared types, codes and the segment table of the seven-segment driver
// no dependencies
package msd_pkg;

	// action codes of an input transfer
	localparam logic [1:0] ACT_SCAN       = 2'd0;
	localparam logic [1:0] ACT_SET_DIGIT  = 2'd1;
	localparam logic [1:0] ACT_SET_NUMBER = 2'd2;
	localparam logic [1:0] ACT_SET_POINT  = 2'd3;

	// register index of active_digits
	localparam logic REG_ACTIVE_DIGITS = 1'b0;
	localparam logic [3:0] ACTIVE_DIGITS_RESET = 4'd1;

	// reciprocal of ten, scaled by 2^35
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	// commands from controller to datapath
	typedef struct packed {
		logic scan;
		logic set_digit;
		logic set_point;
		logic conv_load;
		logic conv_mul;
		logic conv_step;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic conv_last;
	} status_t;

	// active-low segments a..g for one decimal value, invalid codes show eight
	function automatic logic [6:0] seg_decode(input logic [3:0] val);
		logic [6:0] seg;
		case (val)
			4'd0: seg = 7'h40;
			4'd1: seg = 7'h79;
			4'd2: seg = 7'h24;
			4'd3: seg = 7'h30;
			4'd4: seg = 7'h19;
			4'd5: seg = 7'h12;
			4'd6: seg = 7'h02;
			4'd7: seg = 7'h78;
			4'd8: seg = 7'h00;
			4'd9: seg = 7'h10;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage

// ----- rtl/msd_ctrl.sv -----
// controller of the seven-segment driver: decodes actions and sequences number conversion
// depends on msd_pkg and multiplexed_seven_segment_driver_defines.svh
`include "multiplexed_seven_segment_driver_defines.svh"

module msd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       action,
	input  msd_pkg::status_t status,
	output msd_pkg::cmd_t    cmd,
	output logic             busy
);
	import msd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SUB  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_SCAN:      cmd.scan = 1'b1;
						ACT_SET_DIGIT: cmd.set_digit = 1'b1;
						ACT_SET_NUMBER: begin
							cmd.conv_load = 1'b1;
							state_d       = ST_MUL;
						end
						ACT_SET_POINT: cmd.set_point = 1'b1;
						default:       cmd = '0;
					endcase
				end
			end
			ST_MUL: begin
				cmd.conv_mul = 1'b1;
				state_d      = ST_SUB;
			end
			ST_SUB: begin
				cmd.conv_step = 1'b1;
				state_d       = status.conv_last ? ST_IDLE : ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	`MSD_ASSERT_NEXT(a_conv_goes_busy, accept && (action == ACT_SET_NUMBER), busy, "conversion not started")
	`MSD_ASSERT_NEXT(a_conv_ends_idle, cmd.conv_step && status.conv_last, !busy, "conversion did not end")
	`MSD_ASSERT_SAME(a_step_after_mul, cmd.conv_step, $past(cmd.conv_mul), "step without multiply")
	`MSD_ASSERT_ALWAYS(a_one_command, $onehot0(cmd), "more than one command")

endmodule

// ----- rtl/msd_datapath.sv -----
// datapath of the seven-segment driver: digit store, scan pointer, divide-by-ten unit
// depends on msd_pkg
module msd_datapath #(
	parameter int MAX_DIGIT_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  msd_pkg::cmd_t    cmd,
	output msd_pkg::status_t status,
	input  logic [3:0]       active_digits,
	input  logic [2:0]       digit_index,
	input  logic [31:0]      data_word,
	input  logic             dp_flag,
	output logic             result_valid,
	output logic [6:0]       segments_n,
	output logic             point_n,
	output logic [7:0]       digit_enable
);
	import msd_pkg::*;

	localparam int PTR_W = (MAX_DIGIT_COUNT > 1) ? $clog2(MAX_DIGIT_COUNT) : 1;
	localparam int CNT_W = $clog2(MAX_DIGIT_COUNT + 1);

	logic [3:0]       store_val_q [MAX_DIGIT_COUNT];
	logic             store_pt_q  [MAX_DIGIT_COUNT];
	logic [PTR_W-1:0] scan_ptr_q;
	logic [PTR_W-1:0] conv_pos_q;
	logic [31:0]      conv_x_q;
	logic [28:0]      conv_q_q;
	logic [CNT_W-1:0] eff_n;
	logic [PTR_W-1:0] scan_p;
	logic [PTR_W-1:0] scan_next;
	logic [63:0]      recip_prod;
	logic [3:0]       conv_rem;
	logic             idx_ok;
	logic             val_ok;
	logic             result_valid_q;
	logic [6:0]       segments_n_q;
	logic             point_n_q;
	logic [7:0]       digit_enable_q;

	// active count clamped to 1..MAX_DIGIT_COUNT
	always_comb begin
		if (active_digits == 4'd0) begin
			eff_n = CNT_W'(1);
		end else if (int'(active_digits) > MAX_DIGIT_COUNT) begin
			eff_n = CNT_W'(MAX_DIGIT_COUNT);
		end else begin
			eff_n = CNT_W'(active_digits);
		end
	end

	// scan pointer wraps when out of range
	assign scan_p    = (int'(scan_ptr_q) >= int'(eff_n)) ? '0 : scan_ptr_q;
	assign scan_next = ((int'(scan_p) + 1) == int'(eff_n)) ? '0 : PTR_W'(scan_p + 1'b1);

	// write qualifiers for single-digit actions
	assign idx_ok = (int'(digit_index) < MAX_DIGIT_COUNT);
	assign val_ok = (data_word <= 32'd9);

	// divide by ten: reciprocal product, then low-digit remainder
	assign recip_prod = 64'(conv_x_q) * 64'(RECIP_TEN);
	assign conv_rem   = conv_x_q[3:0] - 4'(conv_q_q[3:0] * 4'd10);

	assign status.conv_last = (conv_pos_q == '0);

	// digit store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
				store_val_q[i] <= 4'd0;
				store_pt_q[i]  <= 1'b0;
			end
		end else begin
			for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
				if (cmd.set_digit && idx_ok && val_ok && (int'(digit_index) == i)) begin
					store_val_q[i] <= data_word[3:0];
					store_pt_q[i]  <= dp_flag;
				end
				if (cmd.set_point && idx_ok && (int'(digit_index) == i)) begin
					store_pt_q[i] <= data_word[0];
				end
				if (cmd.conv_step && (int'(conv_pos_q) == i)) begin
					store_val_q[i] <= conv_rem;
					store_pt_q[i]  <= 1'b0;
				end
			end
		end
	end

	// scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q <= '0;
		end else if (cmd.scan) begin
			scan_ptr_q <= scan_next;
		end
	end

	// conversion working registers
	always_ff @(posedge clk) begin
		if (cmd.conv_load) begin
			conv_x_q   <= data_word;
			conv_pos_q <= PTR_W'(eff_n - 1'b1);
		end
		if (cmd.conv_mul) begin
			conv_q_q <= recip_prod[RECIP_SHIFT +: 29];
		end
		if (cmd.conv_step) begin
			conv_x_q   <= 32'(conv_q_q);
			conv_pos_q <= conv_pos_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.scan;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			segments_n_q <= seg_decode(store_val_q[scan_p]);
			point_n_q    <= !store_pt_q[scan_p];
			for (int i = 0; i < 8; i++) begin
				digit_enable_q[i] <= (int'(scan_p) == i);
			end
		end
	end

	assign result_valid = result_valid_q;
	assign segments_n   = segments_n_q;
	assign point_n      = point_n_q;
	assign digit_enable = digit_enable_q;

endmodule

// ----- rtl/multiplexed_seven_segment_driver.sv -----
// top level of the multiplexed seven-segment driver: config register and core wiring
// depends on msd_pkg, msd_ctrl and msd_datapath
//
// Usage:
// - Command channel: an item (action, digit_index, data_word, dp_flag) is taken at a
//   rising edge with start high and busy low.
// - Scan tick, set digit and set point leave busy low, so one may follow every
//   cycle. A scan tick puts its result on segments_n, point_n and digit_enable in
//   the cycle after the transfer, marked by result_valid for one cycle.
// - Set number runs one divide-by-ten step per active digit through a shared
//   reciprocal multiplier; each step is a multiply state then a remainder state, so
//   busy stays high until the steps for the clamped digit count (active_digits
//   limited to 1..MAX_DIGIT_COUNT) are done.
// - Other actions give no result.
// - The receiver cannot stall; a result is shown for exactly one cycle.
// - active_digits lives at byte address 0 of the APB port; the user must write it
//   only while the block is idle, as the block itself does not enforce this.
// - Reset clears the digit store, the scan pointer and the controller, and sets
//   active_digits to one.
module multiplexed_seven_segment_driver #(
	parameter int MAX_DIGIT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [2:0]  digit_index,
	input  logic [31:0] data_word,
	input  logic        dp_flag,
	// result channel
	output logic        result_valid,
	output logic [6:0]  segments_n,
	output logic        point_n,
	output logic [7:0]  digit_enable,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import msd_pkg::*;

	logic [3:0] active_digits_q;
	logic       cfg_write;
	cmd_t       cmd;
	status_t    status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_digits_q <= ACTIVE_DIGITS_RESET;
		end else if (cfg_write && (paddr[2] == REG_ACTIVE_DIGITS)) begin
			active_digits_q <= pwdata[3:0];
		end
	end

	// register readback
	assign prdata = (paddr[2] == REG_ACTIVE_DIGITS) ? 32'(active_digits_q) : 32'd0;

	msd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	msd_datapath #(
		.MAX_DIGIT_COUNT (MAX_DIGIT_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.active_digits (active_digits_q),
		.digit_index   (digit_index),
		.data_word     (data_word),
		.dp_flag       (dp_flag),
		.result_valid  (result_valid),
		.segments_n    (segments_n),
		.point_n       (point_n),
		.digit_enable  (digit_enable)
	);

endmodule
